// ===== hw/rtl/odo_pkg.sv =====
package odo_pkg;

	// Sizing of the trip counter bank, of the rotation and square root phases and of the step counter.
	localparam int NUM_TRIP_UNITS = 4;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int SQRT_STEPS = 27;
	localparam int ROT_STEPS = 8;
	localparam int SQ_STEPS = 2;
	localparam int CNT_W = 5;

	// Angle constants in Q12 radians and the CORDIC gain in Q30.
	localparam logic signed [16:0] PI_Q12 = 17'sd12868;
	localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
	localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
	localparam logic signed [32:0] GAIN_Q30 = 33'sh026DD3B6A;

	// Register indexes of the configuration port.
	localparam logic REG_OFFSET_X = 1'b0;
	localparam logic REG_OFFSET_Y = 1'b1;

	// Function codes of an input transaction.
	typedef enum logic [1:0] {
		FUNC_UPDATE = 2'd0,
		FUNC_MEASURE = 2'd1,
		FUNC_BEGIN = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_YAW,
		ST_CORRX,
		ST_CORRY,
		ST_CORDIC,
		ST_ROT,
		ST_SQ,
		ST_SQRT,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_YAW,
		OP_CORRX,
		OP_CORRY,
		OP_CORDIC,
		OP_ROT,
		OP_SQ,
		OP_SQRT,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CNT_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
	} sts_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic signed [33:0] atan_q30(input logic [CNT_W-1:0] i);
		logic signed [33:0] r;
		begin
			case (i)
				5'd0: r = 34'sh03243F6A8;
				5'd1: r = 34'sh01DAC6705;
				5'd2: r = 34'sh00FADBAFC;
				5'd3: r = 34'sh007F56EA6;
				5'd4: r = 34'sh003FEAB76;
				5'd5: r = 34'sh001FFD55B;
				5'd6: r = 34'sh000FFFAAA;
				5'd7: r = 34'sh0007FFF55;
				5'd8: r = 34'sh0003FFFEA;
				5'd9: r = 34'sh0001FFFFD;
				5'd10: r = 34'sh0000FFFFF;
				5'd11: r = 34'sh00007FFFF;
				5'd12: r = 34'sh00003FFFF;
				5'd13: r = 34'sh00001FFFF;
				5'd14: r = 34'sh00000FFFF;
				5'd15: r = 34'sh000007FFF;
				5'd16: r = 34'sh000003FFF;
				5'd17: r = 34'sh000001FFF;
				5'd18: r = 34'sh000000FFF;
				5'd19: r = 34'sh0000007FF;
				5'd20: r = 34'sh0000003FF;
				5'd21: r = 34'sh0000001FF;
				5'd22: r = 34'sh0000000FF;
				5'd23: r = 34'sh00000007F;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== hw/rtl/odo_ctrl.sv =====
module odo_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [1:0] func,
	input  odo_pkg::sts_t sts,
	output logic in_ready,
	output odo_pkg::cmd_t cmd
);

	odo_pkg::state_t state_q, state_d;
	logic [odo_pkg::CNT_W-1:0] cnt_q;
	logic counting;
	logic last;

	// End of each counted phase.
	always_comb begin
		counting = 1'b0;
		last = 1'b0;
		unique case (state_q)
			odo_pkg::ST_CORDIC: begin
				counting = 1'b1;
				last = (cnt_q == odo_pkg::CNT_W'(odo_pkg::CORDIC_N - 1));
			end
			odo_pkg::ST_ROT: begin
				counting = 1'b1;
				last = (cnt_q == odo_pkg::CNT_W'(odo_pkg::ROT_STEPS - 1));
			end
			odo_pkg::ST_SQ: begin
				counting = 1'b1;
				last = (cnt_q == odo_pkg::CNT_W'(odo_pkg::SQ_STEPS - 1));
			end
			odo_pkg::ST_SQRT: begin
				counting = 1'b1;
				last = (cnt_q == odo_pkg::CNT_W'(odo_pkg::SQRT_STEPS - 1));
			end
			default: begin
				counting = 1'b0;
				last = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			odo_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (func == odo_pkg::FUNC_UPDATE) ? odo_pkg::ST_YAW : odo_pkg::ST_FIN;
				end
			end
			odo_pkg::ST_YAW: state_d = odo_pkg::ST_CORRX;
			odo_pkg::ST_CORRX: state_d = odo_pkg::ST_CORRY;
			odo_pkg::ST_CORRY: state_d = odo_pkg::ST_CORDIC;
			odo_pkg::ST_CORDIC: if (last) state_d = odo_pkg::ST_ROT;
			odo_pkg::ST_ROT: if (last) state_d = odo_pkg::ST_SQ;
			odo_pkg::ST_SQ: if (last) state_d = odo_pkg::ST_SQRT;
			odo_pkg::ST_SQRT: if (last) state_d = odo_pkg::ST_FIN;
			odo_pkg::ST_FIN: if (sts.slot_free) state_d = odo_pkg::ST_IDLE;
			default: state_d = odo_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		in_ready = 1'b0;
		cmd.step = cnt_q;
		cmd.op = odo_pkg::OP_NONE;
		unique case (state_q)
			odo_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.op = in_valid ? odo_pkg::OP_LOAD : odo_pkg::OP_NONE;
			end
			odo_pkg::ST_YAW: cmd.op = odo_pkg::OP_YAW;
			odo_pkg::ST_CORRX: cmd.op = odo_pkg::OP_CORRX;
			odo_pkg::ST_CORRY: cmd.op = odo_pkg::OP_CORRY;
			odo_pkg::ST_CORDIC: cmd.op = odo_pkg::OP_CORDIC;
			odo_pkg::ST_ROT: cmd.op = odo_pkg::OP_ROT;
			odo_pkg::ST_SQ: cmd.op = odo_pkg::OP_SQ;
			odo_pkg::ST_SQRT: cmd.op = odo_pkg::OP_SQRT;
			odo_pkg::ST_FIN: cmd.op = odo_pkg::OP_FIN;
			default: cmd.op = odo_pkg::OP_NONE;
		endcase
	end

	// State register and phase step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= odo_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (counting && !last) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	a_update_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == odo_pkg::ST_IDLE && in_valid && func == odo_pkg::FUNC_UPDATE)
		|=> state_q == odo_pkg::ST_YAW)
		else $error("update transaction did not start the heading phase");
	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == odo_pkg::ST_CORDIC |-> cnt_q < odo_pkg::CNT_W'(odo_pkg::CORDIC_N))
		else $error("rotation step counter out of range");
	a_sqrt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == odo_pkg::ST_SQRT |-> cnt_q < odo_pkg::CNT_W'(odo_pkg::SQRT_STEPS))
		else $error("square root step counter out of range");
	a_fin_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == odo_pkg::ST_FIN && !sts.slot_free) |=> state_q == odo_pkg::ST_FIN)
		else $error("result dropped while output slot busy");

endmodule

// ===== hw/rtl/odo_dp.sv =====
module odo_dp (
	input  logic clk,
	input  logic arst_n,
	input  odo_pkg::cmd_t cmd,
	output odo_pkg::sts_t sts,
	input  logic [1:0] func,
	input  logic signed [23:0] disp_x,
	input  logic signed [23:0] disp_y,
	input  logic signed [14:0] heading_in,
	input  logic [1:0] unit_sel,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic signed [23:0] cfg_wdata,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [14:0] heading_out,
	output logic [39:0] trip_value
);

	// Configuration and latched transaction fields.
	logic signed [23:0] offx_q, offy_q;
	logic [1:0] func_q;
	logic signed [23:0] dx_q, dy_q;
	logic signed [14:0] hin_q;
	logic [1:0] unit_q;

	// Working registers.
	logic signed [15:0] dyaw_q;
	logic signed [26:0] cx_q, cy_q;
	logic signed [32:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic neg_q;
	logic signed [63:0] acc_q;
	logic signed [34:0] gx_q, gy_q;
	logic [53:0] rad_q;
	logic [28:0] rem_q;
	logic [26:0] root_q;

	// Architectural state.
	logic signed [47:0] posx_q, posy_q;
	logic signed [14:0] head_q;
	logic [39:0] trip_q [odo_pkg::NUM_TRIP_UNITS];

	// Result register.
	logic out_valid_q;
	logic signed [47:0] outx_q, outy_q;
	logic signed [14:0] outh_q;
	logic [39:0] outt_q;

	logic fin_en;
	assign sts.slot_free = !out_valid_q || out_ready;
	assign fin_en = (cmd.op == odo_pkg::OP_FIN) && sts.slot_free;

	// Heading change, wrapped once into plus or minus pi.
	logic signed [16:0] d0, d1, d2;
	always_comb begin
		d0 = 17'(hin_q) - 17'(head_q);
		d1 = (d0 < -odo_pkg::PI_Q12) ? d0 + odo_pkg::TWO_PI_Q12 : d0;
		d2 = (d1 > odo_pkg::PI_Q12) ? d1 - odo_pkg::TWO_PI_Q12 : d1;
	end

	// Reduction of the heading into plus or minus pi/2.
	logic signed [15:0] ang, ang_red;
	logic ang_neg;
	always_comb begin
		ang = 16'(hin_q);
		ang_neg = 1'b0;
		ang_red = ang;
		if (ang > odo_pkg::HALF_PI_Q12) begin
			ang_red = ang - 16'(odo_pkg::PI_Q12);
			ang_neg = 1'b1;
		end else if (ang < -odo_pkg::HALF_PI_Q12) begin
			ang_red = ang + 16'(odo_pkg::PI_Q12);
			ang_neg = 1'b1;
		end
	end

	// Rotation product selection: gx = cx*c - cy*s, gy = cx*s + cy*c.
	logic [2:0] k;
	logic signed [32:0] sin_v, cos_v, trig;
	logic signed [26:0] trig_half;
	assign k = cmd.step[2:0];
	always_comb begin
		sin_v = neg_q ? -y_q : y_q;
		cos_v = neg_q ? -x_q : x_q;
		trig = (k[2] ^ k[1]) ? sin_v : cos_v;
		if (k[0]) begin
			trig_half = 27'(signed'(trig[32:16]));
		end else begin
			trig_half = signed'({11'b0, trig[15:0]});
		end
	end

	// Shared multiplier.
	logic signed [26:0] mul_a, mul_b;
	logic signed [53:0] prod;
	always_comb begin
		mul_a = 27'(dyaw_q);
		mul_b = 27'(offx_q);
		case (cmd.op)
			odo_pkg::OP_CORRY: mul_b = 27'(offy_q);
			odo_pkg::OP_ROT: begin
				mul_a = k[1] ? cy_q : cx_q;
				mul_b = trig_half;
			end
			odo_pkg::OP_SQ: begin
				mul_a = cmd.step[0] ? cy_q : cx_q;
				mul_b = cmd.step[0] ? cy_q : cx_q;
			end
			default: begin
				mul_a = 27'(dyaw_q);
				mul_b = 27'(offx_q);
			end
		endcase
		prod = mul_a * mul_b;
	end

	// Lever arm correction: disp + round(dyaw * offset / 4096).
	logic signed [53:0] corr_rnd, corr_sh;
	logic signed [26:0] corr_new;
	always_comb begin
		corr_rnd = prod + 54'sd2048;
		corr_sh = corr_rnd >>> 12;
		corr_new = (cmd.op == odo_pkg::OP_CORRY) ? 27'(dy_q) : 27'(dx_q);
		corr_new = corr_new + signed'(corr_sh[26:0]);
	end

	// Rotation accumulate and rounding.
	logic signed [63:0] term, rot_sum, rot_rnd;
	always_comb begin
		term = k[0] ? (64'(prod) <<< 16) : 64'(prod);
		if (!k[2] && k[1]) begin
			term = -term;
		end
		rot_sum = ((k[1:0] == 2'd0) ? 64'sd0 : acc_q) + term;
		rot_rnd = (rot_sum + 64'sd536870912) >>> 30;
	end

	// CORDIC micro-rotation.
	logic signed [32:0] x_sh, y_sh;
	assign x_sh = x_q >>> cmd.step;
	assign y_sh = y_q >>> cmd.step;

	// Square root digit step.
	logic [28:0] rem_try, trial;
	assign rem_try = {rem_q[26:0], rad_q[53:52]};
	assign trial = {root_q, 2'b01};

	// Completion values of the architectural state.
	logic signed [48:0] sx, sy;
	logic signed [47:0] nposx, nposy;
	logic [40:0] tsum [odo_pkg::NUM_TRIP_UNITS];
	logic [39:0] trip_sel;
	always_comb begin
		sx = 49'(posx_q) + 49'(gx_q);
		sy = 49'(posy_q) + 49'(gy_q);
		nposx = (sx[48] != sx[47]) ? {sx[48], {47{~sx[48]}}} : sx[47:0];
		nposy = (sy[48] != sy[47]) ? {sy[48], {47{~sy[48]}}} : sy[47:0];
		trip_sel = '0;
		for (int i = 0; i < odo_pkg::NUM_TRIP_UNITS; i++) begin
			tsum[i] = {1'b0, trip_q[i]} + 41'(root_q);
			if (5'(unit_q) == 5'(i)) begin
				trip_sel = trip_q[i];
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offx_q <= '0;
			offy_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == odo_pkg::REG_OFFSET_X) begin
				offx_q <= cfg_wdata;
			end else begin
				offy_q <= cfg_wdata;
			end
		end
	end

	// Working datapath registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			odo_pkg::OP_LOAD: begin
				func_q <= func;
				dx_q <= disp_x;
				dy_q <= disp_y;
				hin_q <= heading_in;
				unit_q <= unit_sel;
			end
			odo_pkg::OP_YAW: begin
				dyaw_q <= d2[15:0];
				x_q <= odo_pkg::GAIN_Q30;
				y_q <= '0;
				z_q <= 34'(ang_red) <<< 18;
				neg_q <= ang_neg;
			end
			odo_pkg::OP_CORRX: cx_q <= corr_new;
			odo_pkg::OP_CORRY: cy_q <= corr_new;
			odo_pkg::OP_CORDIC: begin
				if (!z_q[33]) begin
					x_q <= x_q - y_sh;
					y_q <= y_q + x_sh;
					z_q <= z_q - odo_pkg::atan_q30(cmd.step);
				end else begin
					x_q <= x_q + y_sh;
					y_q <= y_q - x_sh;
					z_q <= z_q + odo_pkg::atan_q30(cmd.step);
				end
			end
			odo_pkg::OP_ROT: begin
				acc_q <= rot_sum;
				if (k == 3'd3) gx_q <= rot_rnd[34:0];
				if (k == 3'd7) gy_q <= rot_rnd[34:0];
			end
			odo_pkg::OP_SQ: begin
				if (!cmd.step[0]) begin
					acc_q <= 64'(prod);
				end else begin
					rad_q <= 54'(acc_q + 64'(prod));
					rem_q <= '0;
					root_q <= '0;
				end
			end
			odo_pkg::OP_SQRT: begin
				rad_q <= rad_q << 2;
				if (rem_try >= trial) begin
					rem_q <= rem_try - trial;
					root_q <= {root_q[25:0], 1'b1};
				end else begin
					rem_q <= rem_try;
					root_q <= {root_q[25:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// Position, heading and trip counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posx_q <= '0;
			posy_q <= '0;
			head_q <= '0;
			for (int i = 0; i < odo_pkg::NUM_TRIP_UNITS; i++) begin
				trip_q[i] <= '0;
			end
		end else if (fin_en) begin
			case (func_q)
				odo_pkg::FUNC_UPDATE: begin
					posx_q <= nposx;
					posy_q <= nposy;
					head_q <= hin_q;
					for (int i = 0; i < odo_pkg::NUM_TRIP_UNITS; i++) begin
						trip_q[i] <= tsum[i][40] ? '1 : tsum[i][39:0];
					end
				end
				odo_pkg::FUNC_MEASURE: begin
					for (int i = 0; i < odo_pkg::NUM_TRIP_UNITS; i++) begin
						if (5'(unit_q) == 5'(i)) trip_q[i] <= '0;
					end
				end
				odo_pkg::FUNC_BEGIN: begin
					posx_q <= '0;
					posy_q <= '0;
					head_q <= hin_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: loads a result transaction when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_en) begin
			outt_q <= '0;
			case (func_q)
				odo_pkg::FUNC_UPDATE: begin
					outx_q <= nposx;
					outy_q <= nposy;
					outh_q <= hin_q;
				end
				odo_pkg::FUNC_MEASURE: begin
					outx_q <= posx_q;
					outy_q <= posy_q;
					outh_q <= head_q;
					outt_q <= trip_sel;
				end
				odo_pkg::FUNC_BEGIN: begin
					outx_q <= '0;
					outy_q <= '0;
					outh_q <= hin_q;
				end
				default: begin
					outx_q <= posx_q;
					outy_q <= posy_q;
					outh_q <= head_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = outx_q;
	assign pos_y = outy_q;
	assign heading_out = outh_q;
	assign trip_value = outt_q;

	a_fin_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fin_en |=> out_valid_q)
		else $error("completed transaction did not reach the output register");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !fin_en)
		else $error("pending result overwritten");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result withdrawn before it was accepted");

endmodule

// ===== hw/rtl/two_wheel_imu_odometry.sv =====
// An update transaction passes through the phases heading, two correction multiplies, 16 CORDIC
// steps, 8 partial products, 2 squares, 27 square root digits and completion before a valid
// result; measure, begin and other transactions go straight from acceptance to completion.
// One transaction at a time, accepted only when idle; completion waits while the result
// channel stalls.
// Reset (arst_n low): position, heading, trip counters and offsets clear to zero.
module two_wheel_imu_odometry (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic signed [23:0] disp_x,
	input  logic signed [23:0] disp_y,
	input  logic signed [14:0] heading_in,
	input  logic [1:0] unit_sel,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [47:0] pos_x,
	output logic signed [47:0] pos_y,
	output logic signed [14:0] heading_out,
	output logic [39:0] trip_value,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic signed [23:0] cfg_wdata
);

	odo_pkg::cmd_t cmd;
	odo_pkg::sts_t sts;

	// Sequencer.
	odo_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.func(func),
		.sts(sts),
		.in_ready(in_ready),
		.cmd(cmd)
	);

	// Arithmetic and state.
	odo_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.func(func),
		.disp_x(disp_x),
		.disp_y(disp_y),
		.heading_in(heading_in),
		.unit_sel(unit_sel),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading_out(heading_out),
		.trip_value(trip_value)
	);

endmodule
